// File: src/hjsc_pkg.sv
`default_nettype none

package hjsc_pkg;

    // queue between the key classifier and the composer
    localparam int QUEUE_DEPTH = 2;

    // input function codes
    localparam logic [1:0] FUNC_KEY    = 2'd0;
    localparam logic [1:0] FUNC_BKSP   = 2'd1;
    localparam logic [1:0] FUNC_COMMIT = 2'd2;

    // codepoint constants
    localparam logic [15:0] SYL_BASE   = 16'hAC00;
    localparam logic [15:0] JAMO_LO    = 16'h3131;
    localparam logic [15:0] JAMO_HI    = 16'h3163;
    localparam logic [15:0] VOWEL_BASE = 16'h314F;
    localparam logic [5:0]  VOWEL_OFFSET = 6'd30;

    localparam logic [4:0] NONE_IDX      = 5'd31;
    localparam logic [4:0] INITIAL_COUNT = 5'd19;
    localparam logic [4:0] MEDIAL_COUNT  = 5'd21;
    localparam logic [4:0] FINAL_COUNT   = 5'd28;

    // classified operation carried from front to back
    typedef enum logic [2:0] {
        OP_NOP,
        OP_VOWEL,
        OP_CONS,
        OP_BKSP,
        OP_COMMIT
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [4:0]  vow;
        logic [4:0]  key_ini;
        logic [4:0]  key_fin;
        logic [15:0] code;
    } entry_t;

    typedef struct packed {
        logic [15:0] committed_code;
        logic        committed_valid;
        logic [15:0] preview_code;
        logic        preview_valid;
        logic        backspace_passed;
        logic        last_result;
    } res_t;

    // consonant key to initial index
    localparam logic [4:0] KEY_INITIAL [30] = '{
        5'd0, 5'd1, 5'd31, 5'd2, 5'd31, 5'd31, 5'd3, 5'd4, 5'd5, 5'd31,
        5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd6, 5'd7, 5'd8, 5'd31,
        5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18
    };

    // consonant key to final index
    localparam logic [4:0] KEY_FINAL [30] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd0, 5'd8, 5'd9,
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd0, 5'd18,
        5'd19, 5'd20, 5'd21, 5'd22, 5'd0, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27
    };

    localparam logic [4:0] FINAL_AS_INITIAL [28] = '{
        5'd31, 5'd0, 5'd1, 5'd31, 5'd2, 5'd31, 5'd31, 5'd3, 5'd5, 5'd31,
        5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd6, 5'd7, 5'd31, 5'd9,
        5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18
    };

    localparam logic [4:0] FINAL_FIRST [28] = '{
        5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd4, 5'd4, 5'd0, 5'd0, 5'd8,
        5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd0, 5'd0, 5'd17, 5'd0,
        5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
    };

    localparam logic [4:0] FINAL_SECOND [28] = '{
        5'd0, 5'd0, 5'd0, 5'd19, 5'd0, 5'd22, 5'd27, 5'd0, 5'd0, 5'd1,
        5'd16, 5'd17, 5'd19, 5'd25, 5'd26, 5'd27, 5'd0, 5'd0, 5'd19, 5'd0,
        5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
    };

    localparam logic [15:0] INITIAL_COMPAT [19] = '{
        16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141,
        16'h3142, 16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149,
        16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E
    };

    function automatic logic [4:0] final_first_of(input logic [4:0] fin);
        logic [4:0] r;
        r = 5'd0;
        if (fin < FINAL_COUNT)
        begin
            r = FINAL_FIRST[fin];
        end
        return r;
    endfunction

    function automatic logic [4:0] final_second_of(input logic [4:0] fin);
        logic [4:0] r;
        r = 5'd0;
        if (fin < FINAL_COUNT)
        begin
            r = FINAL_SECOND[fin];
        end
        return r;
    endfunction

    function automatic logic [4:0] final_as_initial_of(input logic [4:0] fin);
        logic [4:0] r;
        r = NONE_IDX;
        if (fin < FINAL_COUNT)
        begin
            r = FINAL_AS_INITIAL[fin];
        end
        return r;
    endfunction

    // compound final from two simple finals, 0 when they do not combine
    function automatic logic [4:0] combine_final(input logic [4:0] left,
                                                 input logic [4:0] right);
        logic [4:0] r;
        case ({left, right})
            {5'd1, 5'd19}:  r = 5'd3;
            {5'd4, 5'd22}:  r = 5'd5;
            {5'd4, 5'd27}:  r = 5'd6;
            {5'd8, 5'd1}:   r = 5'd9;
            {5'd8, 5'd16}:  r = 5'd10;
            {5'd8, 5'd17}:  r = 5'd11;
            {5'd8, 5'd19}:  r = 5'd12;
            {5'd8, 5'd25}:  r = 5'd13;
            {5'd8, 5'd26}:  r = 5'd14;
            {5'd8, 5'd27}:  r = 5'd15;
            {5'd17, 5'd19}: r = 5'd18;
            default:        r = 5'd0;
        endcase
        return r;
    endfunction

    // compound vowel from two medials, none when they do not combine
    function automatic logic [4:0] combine_vowel(input logic [4:0] left,
                                                 input logic [4:0] right);
        logic [4:0] r;
        case ({left, right})
            {5'd8, 5'd0}:   r = 5'd9;
            {5'd8, 5'd1}:   r = 5'd10;
            {5'd8, 5'd20}:  r = 5'd11;
            {5'd13, 5'd4}:  r = 5'd14;
            {5'd13, 5'd5}:  r = 5'd15;
            {5'd13, 5'd20}: r = 5'd16;
            {5'd18, 5'd20}: r = 5'd19;
            default:        r = NONE_IDX;
        endcase
        return r;
    endfunction

    // first half of a compound vowel, none for a simple vowel
    function automatic logic [4:0] split_vowel(input logic [4:0] v);
        logic [4:0] r;
        case (v)
            5'd9, 5'd10, 5'd11:  r = 5'd8;
            5'd14, 5'd15, 5'd16: r = 5'd13;
            5'd19:               r = 5'd18;
            default:             r = NONE_IDX;
        endcase
        return r;
    endfunction

    // codepoint of a syllable or lone jamo, 0 when empty
    function automatic logic [15:0] compose(input logic [4:0] ini,
                                            input logic [4:0] med,
                                            input logic [4:0] fin);
        logic [4:0]  f;
        logic [8:0]  lead;
        logic [13:0] offs;
        logic [15:0] r;
        f    = (fin < FINAL_COUNT) ? fin : 5'd0;
        lead = 9'(ini) * 9'd21 + 9'(med);
        offs = 14'(lead) * 14'd28 + 14'(f);
        if (ini < INITIAL_COUNT && med < MEDIAL_COUNT)
        begin
            r = SYL_BASE + 16'(offs);
        end
        else if (ini < INITIAL_COUNT)
        begin
            r = INITIAL_COMPAT[ini];
        end
        else if (med < MEDIAL_COUNT)
        begin
            r = VOWEL_BASE + 16'(med);
        end
        else
        begin
            r = 16'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/hjsc_front.sv
`default_nettype none

module hjsc_front (
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       func,
    input  wire logic [15:0]      jamo_code,
    input  wire logic             queue_full,
    output logic                  push,
    output hjsc_pkg::entry_t      push_data
);

    logic [5:0] key_idx;
    logic       in_range;

    // accept whenever the queue has room
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    assign in_range = (jamo_code >= hjsc_pkg::JAMO_LO) && (jamo_code <= hjsc_pkg::JAMO_HI);
    assign key_idx  = 6'(jamo_code - hjsc_pkg::JAMO_LO);

    // classify the transaction
    always_comb
    begin
        push_data         = '0;
        push_data.op      = hjsc_pkg::OP_NOP;
        push_data.vow     = 5'(key_idx - hjsc_pkg::VOWEL_OFFSET);
        push_data.key_ini = hjsc_pkg::KEY_INITIAL[key_idx[4:0]];
        push_data.key_fin = hjsc_pkg::KEY_FINAL[key_idx[4:0]];
        push_data.code    = jamo_code;
        unique case (func)
            hjsc_pkg::FUNC_KEY:
            begin
                if (in_range)
                begin
                    if (key_idx >= hjsc_pkg::VOWEL_OFFSET)
                    begin
                        push_data.op      = hjsc_pkg::OP_VOWEL;
                        push_data.key_ini = hjsc_pkg::NONE_IDX;
                        push_data.key_fin = 5'd0;
                    end
                    else
                    begin
                        push_data.op = hjsc_pkg::OP_CONS;
                    end
                end
            end
            hjsc_pkg::FUNC_BKSP:   push_data.op = hjsc_pkg::OP_BKSP;
            hjsc_pkg::FUNC_COMMIT: push_data.op = hjsc_pkg::OP_COMMIT;
            default:               push_data.op = hjsc_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// File: src/hjsc_fifo.sv
`default_nettype none

module hjsc_fifo #(
    parameter int DEPTH = hjsc_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire hjsc_pkg::entry_t  push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output hjsc_pkg::entry_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hjsc_pkg::entry_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: src/hjsc_back.sv
`default_nettype none

module hjsc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire hjsc_pkg::entry_t  head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hjsc_pkg::res_t         out_res
);

    logic [4:0]      ini_reg, ini_next;
    logic [4:0]      med_reg, med_next;
    logic [4:0]      fin_reg, fin_next;
    logic            out_valid_reg;
    hjsc_pkg::res_t  out_res_reg;
    logic            second_valid_reg;
    hjsc_pkg::res_t  second_reg;

    logic            ini_ok, med_ok;
    logic [4:0]      cur, ff_cur, vcomb, fcomb;
    logic [15:0]     vcode;
    logic [1:0]      n_emit;
    logic            e1_syl;
    logic [15:0]     e1_lit, e2_lit;
    logic [4:0]      syl_fin;
    logic            passed;
    logic [15:0]     syl_code, preview;
    hjsc_pkg::res_t  res1, res2;
    logic            slot_free;

    assign ini_ok = ini_reg < hjsc_pkg::INITIAL_COUNT;
    assign med_ok = med_reg < hjsc_pkg::MEDIAL_COUNT;
    assign cur    = (fin_reg < hjsc_pkg::FINAL_COUNT) ? fin_reg : 5'd0;
    assign ff_cur = hjsc_pkg::final_first_of(cur);
    assign vcomb  = hjsc_pkg::combine_vowel(med_reg, head.vow);
    assign fcomb  = hjsc_pkg::combine_final(cur, head.key_fin);
    assign vcode  = hjsc_pkg::VOWEL_BASE + 16'(head.vow);

    // syllable state update and emitted codepoints
    always_comb
    begin
        ini_next = ini_reg;
        med_next = med_reg;
        fin_next = fin_reg;
        passed   = 1'b0;
        n_emit   = 2'd0;
        e1_syl   = 1'b1;
        e1_lit   = 16'd0;
        e2_lit   = 16'd0;
        syl_fin  = cur;
        unique case (head.op)
            hjsc_pkg::OP_VOWEL:
            begin
                if (!ini_ok)
                begin
                    n_emit   = 2'd1;
                    e1_syl   = 1'b0;
                    e1_lit   = vcode;
                    ini_next = hjsc_pkg::NONE_IDX;
                    med_next = hjsc_pkg::NONE_IDX;
                    fin_next = 5'd0;
                end
                else if (!med_ok)
                begin
                    med_next = head.vow;
                end
                else if (cur == 5'd0)
                begin
                    if (vcomb != hjsc_pkg::NONE_IDX)
                    begin
                        med_next = vcomb;
                    end
                    else
                    begin
                        n_emit   = 2'd2;
                        syl_fin  = 5'd0;
                        e2_lit   = vcode;
                        ini_next = hjsc_pkg::NONE_IDX;
                        med_next = hjsc_pkg::NONE_IDX;
                        fin_next = 5'd0;
                    end
                end
                else if (ff_cur != 5'd0)
                begin
                    // second half of a compound final starts the next syllable
                    n_emit   = 2'd1;
                    syl_fin  = ff_cur;
                    ini_next = hjsc_pkg::final_as_initial_of(hjsc_pkg::final_second_of(cur));
                    med_next = head.vow;
                    fin_next = 5'd0;
                end
                else
                begin
                    n_emit   = 2'd1;
                    syl_fin  = 5'd0;
                    ini_next = hjsc_pkg::final_as_initial_of(cur);
                    med_next = head.vow;
                    fin_next = 5'd0;
                end
            end
            hjsc_pkg::OP_CONS:
            begin
                if (!ini_ok)
                begin
                    if (head.key_ini != hjsc_pkg::NONE_IDX)
                    begin
                        ini_next = head.key_ini;
                    end
                    else
                    begin
                        n_emit = 2'd1;
                        e1_syl = 1'b0;
                        e1_lit = head.code;
                    end
                end
                else if (med_ok && cur == 5'd0 && head.key_fin != 5'd0)
                begin
                    fin_next = head.key_fin;
                end
                else if (med_ok && cur != 5'd0 && head.key_fin != 5'd0 && fcomb != 5'd0)
                begin
                    fin_next = fcomb;
                end
                else
                begin
                    // commit the syllable; restart with or emit this consonant
                    n_emit   = (head.key_ini == hjsc_pkg::NONE_IDX) ? 2'd2 : 2'd1;
                    e2_lit   = head.code;
                    ini_next = head.key_ini;
                    med_next = hjsc_pkg::NONE_IDX;
                    fin_next = 5'd0;
                end
            end
            hjsc_pkg::OP_BKSP:
            begin
                if (fin_reg != 5'd0 && fin_reg < hjsc_pkg::FINAL_COUNT)
                begin
                    fin_next = hjsc_pkg::final_first_of(fin_reg);
                end
                else if (med_ok)
                begin
                    fin_next = 5'd0;
                    med_next = hjsc_pkg::split_vowel(med_reg);
                end
                else if (ini_ok)
                begin
                    fin_next = 5'd0;
                    ini_next = hjsc_pkg::NONE_IDX;
                end
                else
                begin
                    ini_next = hjsc_pkg::NONE_IDX;
                    med_next = hjsc_pkg::NONE_IDX;
                    fin_next = 5'd0;
                    passed   = 1'b1;
                end
            end
            hjsc_pkg::OP_COMMIT:
            begin
                if (ini_ok || med_ok)
                begin
                    n_emit = 2'd1;
                end
                ini_next = hjsc_pkg::NONE_IDX;
                med_next = hjsc_pkg::NONE_IDX;
                fin_next = 5'd0;
            end
            default:
            begin
                n_emit = 2'd0;
            end
        endcase
    end

    assign syl_code = hjsc_pkg::compose(ini_reg, med_reg, syl_fin);
    assign preview  = hjsc_pkg::compose(ini_next, med_next, fin_next);

    // result items of this transaction
    always_comb
    begin
        res1.committed_code   = (n_emit == 2'd0) ? 16'd0 : (e1_syl ? syl_code : e1_lit);
        res1.committed_valid  = (n_emit != 2'd0);
        res1.preview_code     = preview;
        res1.preview_valid    = (preview != 16'd0);
        res1.backspace_passed = passed;
        res1.last_result      = (n_emit != 2'd2);
        res2                  = res1;
        res2.committed_code   = e2_lit;
        res2.committed_valid  = 1'b1;
        res2.last_result      = 1'b1;
    end

    // output register with a holding slot for the second result
    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = slot_free && !second_valid_reg && head_valid;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ini_reg          <= hjsc_pkg::NONE_IDX;
            med_reg          <= hjsc_pkg::NONE_IDX;
            fin_reg          <= 5'd0;
            out_valid_reg    <= 1'b0;
            second_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            if (second_valid_reg)
            begin
                out_valid_reg    <= 1'b1;
                second_valid_reg <= 1'b0;
            end
            else if (head_valid)
            begin
                ini_reg          <= ini_next;
                med_reg          <= med_next;
                fin_reg          <= fin_next;
                out_valid_reg    <= 1'b1;
                second_valid_reg <= (n_emit == 2'd2);
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (second_valid_reg)
            begin
                out_res_reg <= second_reg;
            end
            else if (head_valid)
            begin
                out_res_reg <= res1;
                second_reg  <= res2;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/hangul_jamo_syllable_composer.sv
// Two-set hangul composer: each transaction is a jamo key, a backspace or a
// commit, and gives one result item, or two when a finished syllable and a
// standalone jamo leave in the same step (last_result marks the end). A
// classifier takes a transaction every cycle while its queue has room and
// writes it to a small queue; the composer takes one queued transaction per
// cycle and delivers one result per cycle through its output register while
// out_ready does not stall it, and it takes no new transaction while the
// second result of a pair is still held. The first result of a transaction
// passes through the queue slot and then the output register. No clearing
// pass is needed after reset.
`default_nettype none

module hangul_jamo_syllable_composer #(
    parameter int QUEUE_DEPTH = hjsc_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] jamo_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      committed_code,
    output logic             committed_valid,
    output logic [15:0]      preview_code,
    output logic             preview_valid,
    output logic             backspace_passed,
    output logic             last_result
);

    logic              queue_full;
    logic              push;
    hjsc_pkg::entry_t  push_data;
    logic              pop;
    logic              head_valid;
    hjsc_pkg::entry_t  head;
    hjsc_pkg::res_t    out_res;

    // key classifier
    hjsc_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .jamo_code  (jamo_code),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // decoupling queue
    hjsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // syllable composer
    hjsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res)
    );

    assign committed_code   = out_res.committed_code;
    assign committed_valid  = out_res.committed_valid;
    assign preview_code     = out_res.preview_code;
    assign preview_valid    = out_res.preview_valid;
    assign backspace_passed = out_res.backspace_passed;
    assign last_result      = out_res.last_result;

endmodule

`default_nettype wire

// File: src/hjsc_checker.sv
`default_nettype none

module hjsc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [15:0] committed_code,
    input  wire logic        committed_valid,
    input  wire logic [15:0] preview_code,
    input  wire logic        preview_valid,
    input  wire logic        backspace_passed,
    input  wire logic        last_result
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(committed_code)
            && $stable(preview_code) && $stable(last_result))
        else $error("stalled result changed");

    // no codepoint means a zero code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !committed_valid |-> committed_code == 16'd0)
        else $error("committed code without valid");

    // empty composition shows a zero preview
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !preview_valid |-> preview_code == 16'd0)
        else $error("preview code without valid");

    // passed backspace emits nothing and leaves nothing in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && backspace_passed |-> !committed_valid && !preview_valid && last_result)
        else $error("passed backspace with content");

    // the first of a pair is followed by the last, which carries a codepoint
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_result |=> out_valid && last_result
            && committed_valid)
        else $error("result pair broken");

endmodule

bind hangul_jamo_syllable_composer hjsc_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .committed_code   (committed_code),
    .committed_valid  (committed_valid),
    .preview_code     (preview_code),
    .preview_valid    (preview_valid),
    .backspace_passed (backspace_passed),
    .last_result      (last_result)
);

`default_nettype wire
